>>> rtl/nata_pkg.sv
// Package for the neighbor attribute table: request and status codes,
// controller state type, and the controller/datapath command struct.
// No dependencies.
package nata_pkg;

	localparam int unsigned ENTRIES_DEF    = 16;
	localparam int unsigned ATTRS_DEF      = 4;
	localparam int unsigned DATA_WIDTH_DEF = 32;
	localparam int unsigned ADDR_WIDTH_DEF = 16;
	localparam int unsigned AGE_W          = 16;
	localparam logic [AGE_W-1:0] AGE_STEP  = 16'd5;
	localparam int unsigned NUM_DEFAULTS   = 4;

	localparam int unsigned REQ_W    = 3;
	localparam int unsigned SEL_W    = 2;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned SIDX_W   = 4;
	localparam int unsigned EVICT_W  = 5;
	localparam int unsigned PADDR_W  = 5;

	localparam logic [REQ_W-1:0] REQ_LOOKUP  = 3'd0;
	localparam logic [REQ_W-1:0] REQ_SET     = 3'd1;
	localparam logic [REQ_W-1:0] REQ_ADD     = 3'd2;
	localparam logic [REQ_W-1:0] REQ_REFRESH = 3'd3;
	localparam logic [REQ_W-1:0] REQ_TICK    = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	localparam logic [2:0] REG_AGE_LIMIT = 3'd0;
	localparam logic [2:0] REG_DEF0      = 3'd1;
	localparam logic [2:0] REG_DEF1      = 3'd2;
	localparam logic [2:0] REG_DEF2      = 3'd3;
	localparam logic [2:0] REG_DEF3      = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DONE
	} nata_state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic execute;
		logic respond;
	} nata_cmd_t;

endpackage

>>> rtl/neighbor_attribute_table_aging.sv
// Top level of the neighbor attribute table with aging: APB registers,
// controller and datapath. Depends on nata_pkg, nata_ctrl, nata_dp.
//
// Usage: raise start with req_type, node_address, attr_sel and write_value
// while busy is low; the request is taken at that edge. busy is high for the
// match and write-back cycle and the attribute read cycle; then result_valid
// pulses for one cycle with status, read_value, slot_index and evicted_count.
// From acceptance to result a request passes match and write-back, the
// registered attribute read and the result register; a new request can be
// taken on the cycle the result is shown, but not while an earlier one is
// still in flight.
// The receiver cannot stall; each result is shown exactly once.
// Registers (APB, byte address 4*i): age_limit, default_attr0..3; pready is
// always high. Write registers only while busy is low and no result pends.
// Reset clears all slot valid flags, registers and the controller at once;
// no clearing pass is needed.
module neighbor_attribute_table_aging
	import nata_pkg::*;
#(
	parameter int unsigned ENTRIES    = ENTRIES_DEF,
	parameter int unsigned ATTRS      = ATTRS_DEF,
	parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int unsigned ADDR_WIDTH = ADDR_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	input  logic                  start,
	output logic                  busy,
	input  logic [REQ_W-1:0]      req_type,
	input  logic [ADDR_WIDTH-1:0] node_address,
	input  logic [SEL_W-1:0]      attr_sel,
	input  logic [DATA_WIDTH-1:0] write_value,
	output logic                  result_valid,
	output logic [STATUS_W-1:0]   status,
	output logic [DATA_WIDTH-1:0] read_value,
	output logic [SIDX_W-1:0]     slot_index,
	output logic [EVICT_W-1:0]    evicted_count
);

	logic [AGE_W-1:0]      age_limit_q;
	logic [DATA_WIDTH-1:0] def_q [NUM_DEFAULTS];
	logic                  wr_en;
	logic [2:0]            reg_idx;
	nata_cmd_t             cmd;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_limit_q <= '0;
			for (int i = 0; i < NUM_DEFAULTS; i++) def_q[i] <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_AGE_LIMIT: age_limit_q <= pwdata[AGE_W-1:0];
				REG_DEF0: def_q[0] <= DATA_WIDTH'(pwdata);
				REG_DEF1: def_q[1] <= DATA_WIDTH'(pwdata);
				REG_DEF2: def_q[2] <= DATA_WIDTH'(pwdata);
				REG_DEF3: def_q[3] <= DATA_WIDTH'(pwdata);
				default: ;
			endcase
		end
	end

	// read back registers
	always_comb begin
		unique case (reg_idx)
			REG_AGE_LIMIT: prdata = 32'(age_limit_q);
			REG_DEF0: prdata = 32'(def_q[0]);
			REG_DEF1: prdata = 32'(def_q[1]);
			REG_DEF2: prdata = 32'(def_q[2]);
			REG_DEF3: prdata = 32'(def_q[3]);
			default: prdata = '0;
		endcase
	end

	nata_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.cmd   (cmd)
	);

	nata_dp #(
		.ENTRIES   (ENTRIES),
		.ATTRS     (ATTRS),
		.DATA_WIDTH(DATA_WIDTH),
		.ADDR_WIDTH(ADDR_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.req_type     (req_type),
		.node_address (node_address),
		.attr_sel     (attr_sel),
		.write_value  (write_value),
		.age_limit    (age_limit_q),
		.default_attr (def_q),
		.done         (result_valid),
		.status       (status),
		.read_value   (read_value),
		.slot_index   (slot_index),
		.evicted_count(evicted_count)
	);

	// a taken request yields a result
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 result_valid)
		else $error("missing result");

	// no result while idle without a request in flight
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result without request");

	// status codes stay in range
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (status == ST_OK || status == ST_MISS || status == ST_FULL))
		else $error("bad status");

endmodule

>>> rtl/nata_ctrl.sv
// Controller for the neighbor attribute table: capture, execute, respond.
// Depends on nata_pkg.
module nata_ctrl
	import nata_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	output nata_cmd_t cmd
);

	nata_state_t state_q, state_d;

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// advance through capture, match and write-back, result
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.execute = 1'b1;
				state_d     = ST_DONE;
			end
			ST_DONE: begin
				cmd.respond = 1'b1;
				state_d     = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

>>> rtl/nata_dp.sv
// Datapath for the neighbor attribute table: slot arrays, parallel match,
// allocation, aging, attribute banks and result registers. Depends on nata_pkg.
module nata_dp
	import nata_pkg::*;
#(
	parameter int unsigned ENTRIES    = ENTRIES_DEF,
	parameter int unsigned ATTRS      = ATTRS_DEF,
	parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int unsigned ADDR_WIDTH = ADDR_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  nata_cmd_t              cmd,
	input  logic [REQ_W-1:0]       req_type,
	input  logic [ADDR_WIDTH-1:0]  node_address,
	input  logic [SEL_W-1:0]       attr_sel,
	input  logic [DATA_WIDTH-1:0]  write_value,
	input  logic [AGE_W-1:0]       age_limit,
	input  logic [DATA_WIDTH-1:0]  default_attr [NUM_DEFAULTS],
	output logic                   done,
	output logic [STATUS_W-1:0]    status,
	output logic [DATA_WIDTH-1:0]  read_value,
	output logic [SIDX_W-1:0]      slot_index,
	output logic [EVICT_W-1:0]     evicted_count
);

	localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

	logic [ENTRIES-1:0]    valid_q;
	logic [ADDR_WIDTH-1:0] addr_q [ENTRIES];
	logic [AGE_W-1:0]      age_q  [ENTRIES];
	logic [DATA_WIDTH-1:0] rdata  [ATTRS];

	logic [REQ_W-1:0]      req_q;
	logic [ADDR_WIDTH-1:0] naddr_q;
	logic [SEL_W-1:0]      sel_q;
	logic [DATA_WIDTH-1:0] wval_q;

	logic [STATUS_W-1:0]   status_q;
	logic [DATA_WIDTH-1:0] rval_q;
	logic [SIDX_W-1:0]     sidx_q;
	logic [EVICT_W-1:0]    evict_q;
	logic                  rhit_q;
	logic                  done_q;

	// match and free-slot priority search
	logic             hit, has_free;
	logic [IDX_W-1:0] hit_idx, free_idx;
	always_comb begin
		hit      = 1'b0;
		has_free = 1'b0;
		hit_idx  = '0;
		free_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (valid_q[i] && addr_q[i] == naddr_q) begin
				hit     = 1'b1;
				hit_idx = IDX_W'(i);
			end
			if (!valid_q[i]) begin
				has_free = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end

	// aged values and expire flags
	logic [AGE_W-1:0]   aged [ENTRIES];
	logic [ENTRIES-1:0] expire;
	logic [CNT_W-1:0]   n_expire;
	always_comb begin
		n_expire = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			aged[i]   = (age_q[i] > ~AGE_STEP) ? '1 : age_q[i] + AGE_STEP;
			expire[i] = valid_q[i] && (aged[i] >= age_limit);
			n_expire  = n_expire + CNT_W'(expire[i]);
		end
	end

	logic             slot_ok;
	logic [IDX_W-1:0] tgt;
	logic             sel_ok;
	always_comb begin
		slot_ok = hit || has_free;
		tgt     = hit ? hit_idx : free_idx;
		sel_ok  = 32'(sel_q) < ATTRS;
	end

	// one bank per attribute word: one write and one registered read a cycle
	for (genvar a = 0; a < ATTRS; a++) begin : g_bank
		logic [DATA_WIDTH-1:0] mem_q [ENTRIES];
		logic                  we;
		logic [DATA_WIDTH-1:0] wd;
		logic [DATA_WIDTH-1:0] rd_q;

		// load the default on allocation, the written value on set
		always_comb begin
			we = 1'b0;
			wd = default_attr[a];
			if (cmd.execute && (req_q == REQ_SET || req_q == REQ_ADD) && slot_ok) begin
				if (!hit) we = 1'b1;
				if (req_q == REQ_SET && sel_ok && 32'(sel_q) == a) begin
					we = 1'b1;
					wd = wval_q;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (we) mem_q[tgt] <= wd;
			if (cmd.execute) rd_q <= mem_q[hit_idx];
		end

		assign rdata[a] = rd_q;
	end

	// capture the request
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q   <= req_type;
			naddr_q <= node_address;
			sel_q   <= attr_sel;
			wval_q  <= write_value;
		end
	end

	// update valid flags and the result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.respond;
			if (cmd.execute) begin
				case (req_q)
					REQ_SET, REQ_ADD: if (!hit && has_free) valid_q[free_idx] <= 1'b1;
					REQ_TICK: if (age_limit != '0) valid_q <= valid_q & ~expire;
					default: ;
				endcase
			end
		end
	end

	// write back slot contents and form the result
	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			status_q <= ST_OK;
			rval_q   <= '0;
			sidx_q   <= '0;
			evict_q  <= '0;
			rhit_q   <= 1'b0;
			case (req_q)
				REQ_LOOKUP: begin
					if (!hit) status_q <= ST_MISS;
					else begin
						sidx_q <= SIDX_W'(hit_idx);
						rhit_q <= 1'b1;
					end
				end
				REQ_SET, REQ_ADD: begin
					if (!slot_ok) status_q <= ST_FULL;
					else begin
						sidx_q <= SIDX_W'(tgt);
						if (!hit) begin
							addr_q[tgt] <= naddr_q;
							age_q[tgt]  <= '0;
						end
						if (req_q == REQ_SET) age_q[tgt] <= '0;
					end
				end
				REQ_REFRESH: begin
					if (!hit) status_q <= ST_MISS;
					else begin
						sidx_q         <= SIDX_W'(hit_idx);
						age_q[hit_idx] <= '0;
					end
				end
				REQ_TICK: begin
					if (age_limit != '0) begin
						evict_q <= EVICT_W'(n_expire);
						for (int i = 0; i < ENTRIES; i++)
							if (valid_q[i]) age_q[i] <= aged[i];
					end
				end
				default: ;
			endcase
		end else if (cmd.respond && rhit_q) begin
			// pick the selected word from the bank reads
			for (int a = 0; a < ATTRS; a++)
				if (32'(sel_q) == a) rval_q <= rdata[a];
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign read_value    = rval_q;
	assign slot_index    = sidx_q;
	assign evicted_count = evict_q;

endmodule

>>> test/neighbor_attribute_table_aging_test.sv
// Self-checking testbench for neighbor_attribute_table_aging: directed table then random
// requests, each result checked against an in-bench table predictor. Depends on nata_pkg.
// Registers are written over APB only while the table is idle.
module neighbor_attribute_table_aging_test;
	import nata_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSLOT = 16;
	localparam int NATTR = 4;

	typedef struct {
		logic [REQ_W-1:0] req;
		logic [15:0] addr;
		logic [SEL_W-1:0] sel;
		logic [31:0] wval;
	} request_t;

	typedef struct {
		logic [STATUS_W-1:0] st;
		logic [31:0] rval;
		logic [SIDX_W-1:0] sidx;
		logic [EVICT_W-1:0] evict;
	} answer_t;

	typedef struct {
		request_t rq;
		logic known;
		answer_t ans;
	} row_t;

	logic clk = 0, arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0, prdata;
	logic pready, start = 0, busy, result_valid;
	logic [REQ_W-1:0] req_type = '0;
	logic [15:0] node_address = '0;
	logic [SEL_W-1:0] attr_sel = '0;
	logic [31:0] write_value = '0, read_value;
	logic [STATUS_W-1:0] status;
	logic [SIDX_W-1:0] slot_index;
	logic [EVICT_W-1:0] evicted_count;

	// predictor state
	bit nb_valid[NSLOT];
	logic [15:0] nb_addr[NSLOT];
	logic [16:0] nb_age[NSLOT];
	logic [31:0] nb_attr[NSLOT][NATTR];
	logic [15:0] lim;
	logic [31:0] dflt[NATTR];

	answer_t pending_answers[$];
	int errors = 0;
	logic [15:0] pool[8];

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	neighbor_attribute_table_aging u_top (.*);

	function automatic int find_node(logic [15:0] a);
		for (int i = 0; i < NSLOT; i++)
			if (nb_valid[i] && nb_addr[i] == a) return i;
		return -1;
	endfunction

	function automatic int alloc_node(logic [15:0] a);
		for (int i = 0; i < NSLOT; i++) begin
			if (!nb_valid[i]) begin
				nb_valid[i] = 1;
				nb_addr[i] = a;
				nb_age[i] = 0;
				for (int k = 0; k < NATTR; k++) nb_attr[i][k] = dflt[k];
				return i;
			end
		end
		return -1;
	endfunction

	function automatic answer_t apply_request(request_t r);
		answer_t o;
		int s;
		o = '{default: '0};
		case (r.req)
			REQ_LOOKUP: begin
				s = find_node(r.addr);
				if (s < 0) o.st = ST_MISS;
				else begin
					o.sidx = SIDX_W'(s);
					o.rval = nb_attr[s][r.sel];
				end
			end
			REQ_SET, REQ_ADD: begin
				s = find_node(r.addr);
				if (s < 0) s = alloc_node(r.addr);
				if (s < 0) o.st = ST_FULL;
				else begin
					o.sidx = SIDX_W'(s);
					if (r.req == REQ_SET) begin
						nb_age[s] = 0;
						nb_attr[s][r.sel] = r.wval;
					end
				end
			end
			REQ_REFRESH: begin
				s = find_node(r.addr);
				if (s < 0) o.st = ST_MISS;
				else begin
					nb_age[s] = 0;
					o.sidx = SIDX_W'(s);
				end
			end
			REQ_TICK: begin
				if (lim != 0) begin
					for (int i = 0; i < NSLOT; i++) begin
						if (nb_valid[i]) begin
							nb_age[i] = 17'(nb_age[i] + 17'd5);
							if (nb_age[i] > 17'd65535) nb_age[i] = 17'd65535;
							if (nb_age[i] >= lim) begin
								nb_valid[i] = 0;
								o.evict++;
							end
						end
					end
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// check each result against the oldest expectation
	always @(posedge clk) begin
		answer_t w;
		if (result_valid) begin
			if (pending_answers.size() == 0) report_mismatch("unexpected result", 0, 0);
			else begin
				w = pending_answers.pop_front();
				if (status !== w.st) report_mismatch("status", 32'(status), 32'(w.st));
				if (read_value !== w.rval) report_mismatch("read_value", read_value, w.rval);
				if (slot_index !== w.sidx)
					report_mismatch("slot_index", 32'(slot_index), 32'(w.sidx));
				if (evicted_count !== w.evict)
					report_mismatch("evicted_count", 32'(evicted_count), 32'(w.evict));
			end
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] v);
		psel <= 1;
		pwrite <= 1;
		paddr <= PADDR_W'(idx) << 2;
		pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		if (idx == REG_AGE_LIMIT) lim = v[15:0];
		else dflt[idx - REG_DEF0] = v;
		// hold the bus idle between transfers
		@(posedge clk);
	endtask

	task automatic issue_request(request_t r, logic known, answer_t ans, bit gaps);
		answer_t p;
		int idle;
		idle = gaps ? $urandom_range(0, 18) : 0;
		// drop start over the idle cycles, then present the request
		if (idle > 0) begin
			start <= 0;
			repeat (idle) @(posedge clk);
		end
		start <= 1;
		req_type <= r.req;
		node_address <= r.addr;
		attr_sel <= r.sel;
		write_value <= r.wval;
		@(posedge clk);
		while (busy) @(posedge clk);
		p = apply_request(r);
		if (known && p != ans) report_mismatch("directed row predictor", 0, 0);
		pending_answers.push_back(p);
	endtask

	task automatic drain_idle();
		start <= 0;
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	function automatic request_t rq(int t, int a, int s, logic [31:0] v);
		request_t r;
		r.req = REQ_W'(t);
		r.addr = 16'(a);
		r.sel = SEL_W'(s);
		r.wval = v;
		return r;
	endfunction

	function automatic answer_t an(int st, logic [31:0] rv, int si, int ev);
		answer_t o;
		o.st = STATUS_W'(st);
		o.rval = rv;
		o.sidx = SIDX_W'(si);
		o.evict = EVICT_W'(ev);
		return o;
	endfunction

	function automatic request_t random_request(bit noise);
		request_t r;
		int u;
		r.sel = SEL_W'($urandom_range(0, 3));
		r.wval = $urandom;
		r.addr = noise ? 16'($urandom) : pool[$urandom_range(0, 7)];
		u = $urandom_range(0, 99);
		if (u < 25) r.req = REQ_LOOKUP;
		else if (u < 45) r.req = REQ_SET;
		else if (u < 65) r.req = REQ_ADD;
		else if (u < 78) r.req = REQ_REFRESH;
		else if (u < 96) r.req = REQ_TICK;
		else r.req = REQ_W'($urandom_range(5, 7));
		return r;
	endfunction

	initial begin
		#1000000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		row_t rows[$];
		answer_t z;
		z = '{default: '0};
		lim = 0;
		foreach (dflt[k]) dflt[k] = 0;
		foreach (nb_valid[i]) begin
			nb_valid[i] = 0;
			nb_age[i] = 0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		write_reg(REG_DEF0, 32'hFFFF_FFFF);
		write_reg(REG_DEF1, 32'h0);
		write_reg(REG_DEF2, 32'hA5A5_5A5A);
		write_reg(REG_DEF3, 32'h1234_5678);

		// directed table: empty-table cases, extremes, fill to full, undefined types
		rows.push_back('{rq(REQ_LOOKUP, 16'hFFFF, 3, 0), 1, an(ST_MISS, 0, 0, 0)});
		rows.push_back('{rq(REQ_REFRESH, 0, 0, 0), 1, an(ST_MISS, 0, 0, 0)});
		rows.push_back('{rq(REQ_TICK, 0, 0, 0), 1, an(ST_OK, 0, 0, 0)});
		rows.push_back('{rq(REQ_ADD, 0, 0, 0), 1, an(ST_OK, 0, 0, 0)});
		rows.push_back('{rq(REQ_LOOKUP, 0, 0, 0), 1, an(ST_OK, 32'hFFFF_FFFF, 0, 0)});
		rows.push_back('{rq(REQ_LOOKUP, 0, 3, 0), 1, an(ST_OK, 32'h1234_5678, 0, 0)});
		rows.push_back('{rq(REQ_ADD, 0, 0, 0), 1, an(ST_OK, 0, 0, 0)});
		rows.push_back('{rq(REQ_SET, 16'hFFFF, 2, 32'hFFFF_FFFF), 1, an(ST_OK, 0, 1, 0)});
		rows.push_back('{rq(REQ_LOOKUP, 16'hFFFF, 2, 0), 1, an(ST_OK, 32'hFFFF_FFFF, 1, 0)});
		rows.push_back('{rq(REQ_LOOKUP, 16'hFFFF, 1, 0), 1, an(ST_OK, 0, 1, 0)});
		rows.push_back('{rq(REQ_REFRESH, 16'hFFFF, 0, 0), 1, an(ST_OK, 0, 1, 0)});
		rows.push_back('{rq(5, 16'h1, 1, 1), 1, z});
		rows.push_back('{rq(7, 16'hFFFF, 3, 32'hFFFF_FFFF), 1, z});
		for (int i = 2; i < NSLOT; i++)
			rows.push_back('{rq(REQ_ADD, 16'h100 + i, 0, 0), 0, z});
		rows.push_back('{rq(REQ_ADD, 16'h7777, 0, 0), 1, an(ST_FULL, 0, 0, 0)});
		rows.push_back('{rq(REQ_SET, 16'h7778, 1, 5), 1, an(ST_FULL, 0, 0, 0)});
		foreach (rows[i]) issue_request(rows[i].rq, rows[i].known, rows[i].ans, 1);
		drain_idle();

		// smallest limit evicts every slot on one tick
		write_reg(REG_AGE_LIMIT, 16'd1);
		issue_request(rq(REQ_TICK, 0, 0, 0), 1, an(ST_OK, 0, 0, 16), 1);
		drain_idle();

		// random phases under different settings
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: write_reg(REG_AGE_LIMIT, 16'hFFFF);
				1: write_reg(REG_AGE_LIMIT, 16'd0);
				2: write_reg(REG_AGE_LIMIT, $urandom_range(5, 40));
				default: write_reg(REG_AGE_LIMIT, $urandom_range(1, 100));
			endcase
			for (int k = 0; k < NATTR; k++)
				write_reg(3'(REG_DEF0 + k), ph == 7 ? 32'h0 : $urandom);
			foreach (pool[j]) pool[j] = 16'($urandom);
			for (int n = 0; n < 200; n++)
				issue_request(random_request($urandom_range(0, 9) == 0), 0, z, 1);
			drain_idle();
		end

		if (errors == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end
endmodule
